### sv/mbps_pkg.sv
// Shared types and constants for the masked byte pattern search block.
package mbps_pkg;

    localparam int BYTE_W   = 8;
    localparam int GRP_SIZE = 8;
    localparam int CMD_W    = 2;
    localparam int S_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_SCAN    = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    typedef struct packed {
        logic win_shift;
        logic win_clear;
        logic pat_shift;
        logic care_clear;
    } cell_ctrl_t;

endpackage

### sv/mbps_cell.sv
// One compare cell: window byte, reversed pattern byte, care bit and match flag.
module mbps_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mbps_pkg::cell_ctrl_t     ctrl,
    input  logic [mbps_pkg::BYTE_W-1:0] win_in,
    input  logic [mbps_pkg::BYTE_W-1:0] pat_in,
    input  logic                     care_in,
    output logic [mbps_pkg::BYTE_W-1:0] win_out,
    output logic [mbps_pkg::BYTE_W-1:0] pat_out,
    output logic                     care_out,
    output logic                     ok
);
    import mbps_pkg::*;

    logic [BYTE_W-1:0] win_reg;
    logic [BYTE_W-1:0] win_next;
    logic [BYTE_W-1:0] pat_reg;
    logic [BYTE_W-1:0] pat_next;
    logic              care_reg;
    logic              care_next;
    logic              ok_reg;
    logic              ok_next;

    always_comb
    begin
        if (ctrl.win_clear)
        begin
            win_next = '0;
        end
        else if (ctrl.win_shift)
        begin
            win_next = win_in;
        end
        else
        begin
            win_next = win_reg;
        end

        pat_next = ctrl.pat_shift ? pat_in : pat_reg;

        if (ctrl.care_clear)
        begin
            care_next = 1'b0;
        end
        else if (ctrl.pat_shift)
        begin
            care_next = care_in;
        end
        else
        begin
            care_next = care_reg;
        end

        // compare against the window as it stands after this cycle's shift
        ok_next = !care_reg || (win_next == pat_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            care_reg <= 1'b0;
            ok_reg   <= 1'b1;
        end
        else
        begin
            win_reg  <= win_next;
            care_reg <= care_next;
            ok_reg   <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

    assign win_out  = win_reg;
    assign pat_out  = pat_reg;
    assign care_out = care_reg;
    assign ok       = ok_reg;

endmodule

### sv/masked_byte_pattern_search.sv
// Scan path: a scan request passes the cell-compare, group-AND and decision registers in turn.
// Throughput: clear, append and restart requests every cycle while no scan is in
//   flight; a scan blocks all new requests until it leaves the decision stage.
// A result held at the output stalls the decision stage and with it the input.
// Reset (async, active low) clears window, care bits, length, counter, done flag
//   and scan base; pattern bytes are not reset.
module masked_byte_pattern_search #(
    parameter int MAX_PATTERN = 128,
    parameter int ADDR_BITS   = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ADDR_BITS-1:0]          cfg_wr_data,   // scan_base
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mbps_pkg::S_DATA_W-1:0] s_axis_tdata,  // data_byte[7:0], care[8], zero pad
    input  logic [mbps_pkg::CMD_W-1:0]    s_axis_tuser,  // cmd[1:0]
    input  logic                          s_axis_tlast,  // last_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [((ADDR_BITS+7)/8)*8-1:0] m_axis_tdata, // match_address, zero pad
    output logic                          m_axis_tuser   // found
);
    import mbps_pkg::*;

    localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
    localparam int OUT_W     = ((ADDR_BITS + 7) / 8) * 8;
    localparam int NGRP      = (MAX_PATTERN + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PAD_W     = NGRP * GRP_SIZE;

    cmd_t                 cmd;
    logic [BYTE_W-1:0]    in_byte;
    logic                 in_care;
    logic                 in_acc;
    logic                 scan_go;
    logic                 len_empty;
    logic                 len_full;
    cell_ctrl_t           ctrl;

    logic [ADDR_BITS-1:0] base_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     len_next;
    logic [ADDR_BITS-1:0] bs_reg;
    logic [ADDR_BITS-1:0] bs_next;
    logic                 done_reg;
    logic                 done_next;

    logic                 s1_v_reg;
    logic                 s1_empty_reg;
    logic                 s1_last_reg;
    logic                 s2_v_reg;
    logic                 s2_v_next;
    logic                 s2_empty_reg;
    logic                 s2_last_reg;
    logic                 s2_cover_reg;
    logic [NGRP-1:0]      grp_reg;
    logic [NGRP-1:0]      grp_next;
    logic [ADDR_BITS-1:0] off_reg;

    logic                 s2_adv;
    logic                 hit;
    logic                 emit;
    logic [ADDR_BITS-1:0] addr_sum;
    logic                 out_v_reg;
    logic                 out_v_next;
    logic                 found_reg;
    logic [ADDR_BITS-1:0] addr_reg;

    logic [BYTE_W-1:0]    win_chain  [MAX_PATTERN];
    logic [BYTE_W-1:0]    pat_chain  [MAX_PATTERN];
    logic                 care_chain [MAX_PATTERN];
    logic [BYTE_W-1:0]    win_in     [MAX_PATTERN];
    logic [BYTE_W-1:0]    pat_in     [MAX_PATTERN];
    logic                 care_in    [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] ok_vec;
    logic [PAD_W-1:0]     ok_pad;

    assign cmd     = cmd_t'(s_axis_tuser);
    assign in_byte = s_axis_tdata[BYTE_W-1:0];
    assign in_care = s_axis_tdata[BYTE_W];

    // one scan request in flight at a time
    assign s_axis_tready = !s1_v_reg && !s2_v_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign len_empty     = (len_reg == '0);
    assign len_full      = (len_reg >= LEN_W'(MAX_PATTERN));
    assign scan_go       = in_acc && (cmd == CMD_SCAN) && !done_reg;

    always_comb
    begin
        ctrl.win_shift  = scan_go && !len_empty;
        ctrl.win_clear  = in_acc && (cmd == CMD_RESTART);
        ctrl.pat_shift  = in_acc && (cmd == CMD_APPEND) && !len_full;
        ctrl.care_clear = in_acc && (cmd == CMD_CLEAR);
    end

    // cell row: newest scanned byte and newest pattern byte enter at cell 0
    genvar i;
    generate
        for (i = 0; i < MAX_PATTERN; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign win_in[i]  = in_byte;
                assign pat_in[i]  = in_byte;
                assign care_in[i] = in_care;
            end
            else
            begin : g_link
                assign win_in[i]  = win_chain[i-1];
                assign pat_in[i]  = pat_chain[i-1];
                assign care_in[i] = care_chain[i-1];
            end

            mbps_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .win_in   (win_in[i]),
                .pat_in   (pat_in[i]),
                .care_in  (care_in[i]),
                .win_out  (win_chain[i]),
                .pat_out  (pat_chain[i]),
                .care_out (care_chain[i]),
                .ok       (ok_vec[i])
            );
        end
    endgenerate

    always_comb
    begin
        ok_pad = '1;
        ok_pad[MAX_PATTERN-1:0] = ok_vec;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = &ok_pad[g*GRP_SIZE +: GRP_SIZE];
        end
    end

    // pattern length and byte counter
    always_comb
    begin
        len_next = len_reg;
        if (ctrl.care_clear)
        begin
            len_next = '0;
        end
        else if (ctrl.pat_shift)
        begin
            len_next = len_reg + LEN_W'(1);
        end

        bs_next = bs_reg;
        if (ctrl.win_clear)
        begin
            bs_next = '0;
        end
        else if (ctrl.win_shift && (bs_reg != '1))
        begin
            bs_next = bs_reg + ADDR_BITS'(1);
        end
    end

    // decision stage
    assign s2_adv   = s2_v_reg && (!out_v_reg || m_axis_tready);
    assign hit      = s2_empty_reg || (s2_cover_reg && (&grp_reg));
    assign emit     = hit || s2_last_reg;
    assign addr_sum = base_reg + (s2_empty_reg ? '0 : off_reg);

    always_comb
    begin
        done_next = done_reg;
        if (ctrl.win_clear)
        begin
            done_next = 1'b0;
        end
        else if (s2_adv && emit)
        begin
            done_next = 1'b1;
        end

        s2_v_next = s1_v_reg || (s2_v_reg && !s2_adv);

        if (s2_adv && emit)
        begin
            out_v_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            len_reg   <= '0;
            bs_reg    <= '0;
            done_reg  <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
            len_reg   <= len_next;
            bs_reg    <= bs_next;
            done_reg  <= done_next;
            s1_v_reg  <= scan_go;
            s2_v_reg  <= s2_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_go)
        begin
            s1_empty_reg <= len_empty;
            s1_last_reg  <= s_axis_tlast;
        end
        if (s1_v_reg)
        begin
            grp_reg      <= grp_next;
            off_reg      <= bs_reg - ADDR_BITS'(len_reg);
            s2_cover_reg <= (bs_reg >= ADDR_BITS'(len_reg));
            s2_empty_reg <= s1_empty_reg;
            s2_last_reg  <= s1_last_reg;
        end
        if (s2_adv && emit)
        begin
            found_reg <= hit;
            addr_reg  <= hit ? addr_sum : '0;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tuser  = found_reg;
    assign m_axis_tdata  = OUT_W'(addr_reg);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_v_reg && s2_v_reg))
        else $error("two scan requests in flight");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_PATTERN))
        else $error("pattern length beyond maximum");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (addr_reg == '0))
        else $error("not-found result with nonzero address");

    a_result_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> done_reg)
        else $error("result without scan done");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg |=> (s2_v_reg && !s1_v_reg))
        else $error("scan pipeline lost a request");

endmodule
